// File: src/hevc_rtp_fu_packetizer_macros.svh
// Assertion macros used by the packetizer top level.
`ifndef HEVC_RTP_FU_PACKETIZER_MACROS_SVH
`define HEVC_RTP_FU_PACKETIZER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HRFP_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HRFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/hrfp_pkg.sv
// Types and constants shared by the packetizer modules.
package hrfp_pkg;

	localparam int MAX_CHUNK_DEF   = 1400;
	localparam int LENGTH_BITS_DEF = 20;

	// Largest number of stream bytes one input byte can cause.
	localparam int MAX_RES = 20;
	localparam int IDX_W   = $clog2(MAX_RES);

	// Byte slots inside one result run.
	localparam int IDX_DATA_NONE  = 0;
	localparam int IDX_DATA_PLAIN = 16;
	localparam int IDX_DATA_FU    = 19;

	localparam logic [7:0] FRAME_MAGIC  = 8'h24; // '$'
	localparam logic [7:0] RTP_VER      = 8'h80;
	localparam logic [6:0] RTP_PT       = 7'd96;
	localparam logic [7:0] SSRC_B0      = 8'h12;
	localparam logic [7:0] SSRC_B1      = 8'h34;
	localparam logic [7:0] SSRC_B2      = 8'h56;
	localparam logic [7:0] SSRC_B3      = 8'h78;
	localparam logic [7:0] FU_IND_B0    = 8'h62; // type 49 shifted into place
	localparam logic [7:0] FU_IND_B1    = 8'h01;
	localparam int         RTP_HDR_LEN  = 12;
	localparam int         FU_HDR_LEN   = 15;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [19:0] nal_length;
		logic [31:0] timestamp;
		logic        nal_first;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       run_last;
	} out_t;

	// Result run for one accepted input byte.
	typedef struct packed {
		logic                     has;
		logic [MAX_RES-1:0][7:0]  bytes;
		idx_t                     last_idx;
		logic                     data_end;
	} job_t;

	typedef struct packed {
		logic busy;
		logic ready;
	} emit_st_t;

endpackage

// File: src/hevc_rtp_fu_packetizer.sv
// Top level of the HEVC RTP packetizer for interleaved TCP transport.
//
// in channel: one NAL byte per request (in_valid / in_stall), with the
// NAL length and timestamp sampled on the request that has nal_first set.
// out channel: one byte of the '$'-framed RTP stream per request
// (out_valid / out_stall); frame_end marks the last byte of a frame and
// run_last the last byte caused by one input request.
// cfg_we / cfg_wdata set the interleaved channel id; write it while idle.
//
// The first output byte of a request passes through the run register and then
// the output register after the input is accepted. A payload byte causes one
// output byte; a byte that opens a packet causes 17 output bytes (plain NAL) or
// 20 (fragment), walked out by the single output byte port. The two header
// bytes of a fragmented NAL, and bytes with no NAL open, cause no output.
// A new request is taken in the same cycle the previous run's last byte
// moves to the output register, so the output register and the run register
// keep both sides moving.
// Reset: sequence number 0, no NAL open, channel id 0, output empty.
// Receiver stall: the output byte is held, the run register fills, and the
// input then stalls until the run can drain.
module hevc_rtp_fu_packetizer import hrfp_pkg::*; #(
	parameter int MAX_CHUNK   = MAX_CHUNK_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_t        in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_t       out_data
);

	`include "hevc_rtp_fu_packetizer_macros.svh"

	job_t     job;
	emit_st_t emit_st;
	logic     in_accept;

	// Hold the input while a run is still being walked out.
	assign in_stall  = !emit_st.ready;
	assign in_accept = in_valid && !in_stall;

	hrfp_front #(
		.MAX_CHUNK   (MAX_CHUNK),
		.LENGTH_BITS (LENGTH_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (in_accept),
		.req       (in_data),
		.job       (job)
	);

	// Drop requests that cause no output; load the rest into the sequencer.
	hrfp_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_accept && job.has),
		.job       (job),
		.st        (emit_st),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	`HRFP_ASSERT_IMPLY(a_end_is_run_last, out_valid && out_data.frame_end, out_data.run_last, "frame end on a byte that is not the last of its run")
	`HRFP_ASSERT_NEXT(a_run_reaches_out, in_accept && job.has, ##1 out_valid, "accepted run did not reach the output")
	`HRFP_ASSERT_IMPLY(a_busy_stalls, emit_st.busy && !emit_st.ready, in_stall, "input taken while a run is still pending")

endmodule

// File: src/hrfp_front.sv
// NAL tracking state and per-byte result run builder.
module hrfp_front import hrfp_pkg::*; #(
	parameter int MAX_CHUNK   = MAX_CHUNK_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       accept,
	input  in_t        req,
	output job_t       job
);

	localparam int LB = LENGTH_BITS;
	localparam int OW = $clog2(MAX_CHUNK);

	logic [7:0]    channel_q;
	logic [15:0]   seq_q;
	logic [LB-1:0] pos_q;
	logic [LB-1:0] total_q;
	logic [31:0]   stamp_q;
	logic          frag_q;
	logic [5:0]    type_q;
	logic          ff_q;
	logic [OW-1:0] off_q;

	logic [31:0]   len_wide;
	logic [LB-1:0] len_in;
	logic [LB-1:0] tot;
	logic [LB-1:0] pos;
	logic [LB-1:0] pos_nxt;
	logic [LB-1:0] rem;
	logic          frag;
	logic [5:0]    ntype;
	logic          ff;
	logic [31:0]   stamp;
	logic [OW-1:0] off;
	logic [OW-1:0] off_nxt;
	logic          off_wrap;
	logic          active;
	logic          pos_ge2;
	logic          last_chunk;
	logic [31:0]   chunk;
	logic [15:0]   rtp_len;
	logic          head;
	logic          fu;
	logic          marker;

	assign len_wide = 32'(req.nal_length);
	assign len_in   = len_wide[LB-1:0];

	// Take the new NAL's context when nal_first is set, the held one otherwise.
	assign tot   = req.nal_first ? len_in : total_q;
	assign pos   = req.nal_first ? '0 : pos_q;
	assign frag  = req.nal_first ? (32'(len_in) > 32'(MAX_CHUNK)) : frag_q;
	assign ntype = req.nal_first ? req.data_byte[6:1] : type_q;
	assign ff    = req.nal_first ? 1'b1 : ff_q;
	assign stamp = req.nal_first ? req.timestamp : stamp_q;
	assign off   = req.nal_first ? '0 : off_q;

	assign active     = pos < tot;
	assign pos_nxt    = pos + LB'(1);
	assign rem        = tot - pos;
	assign pos_ge2    = 32'(pos) >= 32'd2;
	assign off_wrap   = (32'(off) + 32'd1) == 32'(MAX_CHUNK);
	assign off_nxt    = off_wrap ? '0 : off + OW'(1);
	assign last_chunk = 32'(rem) <= 32'(MAX_CHUNK);
	assign chunk      = last_chunk ? 32'(rem) : 32'(MAX_CHUNK);
	assign rtp_len    = frag ? 16'(chunk + 32'(FU_HDR_LEN))
	                         : 16'(32'(tot) + 32'(RTP_HDR_LEN));
	assign head       = active && (frag ? (pos_ge2 && off == '0) : (pos == '0));
	assign fu         = frag && head;
	assign marker     = frag ? last_chunk : 1'b1;

	always_comb begin
		job          = '0;
		job.has      = active && (!frag || pos_ge2);
		job.data_end = (pos_nxt == tot) || (frag && off_wrap);
		if (!head) begin
			job.last_idx = idx_t'(IDX_DATA_NONE);
		end else if (fu) begin
			job.last_idx = idx_t'(IDX_DATA_FU);
		end else begin
			job.last_idx = idx_t'(IDX_DATA_PLAIN);
		end
		job.bytes[0]  = FRAME_MAGIC;
		job.bytes[1]  = channel_q;
		job.bytes[2]  = rtp_len[15:8];
		job.bytes[3]  = rtp_len[7:0];
		job.bytes[4]  = RTP_VER;
		job.bytes[5]  = {marker, RTP_PT};
		job.bytes[6]  = seq_q[15:8];
		job.bytes[7]  = seq_q[7:0];
		job.bytes[8]  = stamp[31:24];
		job.bytes[9]  = stamp[23:16];
		job.bytes[10] = stamp[15:8];
		job.bytes[11] = stamp[7:0];
		job.bytes[12] = SSRC_B0;
		job.bytes[13] = SSRC_B1;
		job.bytes[14] = SSRC_B2;
		job.bytes[15] = SSRC_B3;
		job.bytes[16] = FU_IND_B0;
		job.bytes[17] = FU_IND_B1;
		job.bytes[18] = {ff, last_chunk, ntype};
		job.bytes[job.last_idx] = req.data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q <= '0;
		end else if (cfg_we) begin
			channel_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q   <= '0;
			pos_q   <= '0;
			total_q <= '0;
			stamp_q <= '0;
			frag_q  <= 1'b0;
			type_q  <= '0;
			ff_q    <= 1'b1;
			off_q   <= '0;
		end else if (accept) begin
			if (req.nal_first) begin
				total_q <= len_in;
				stamp_q <= req.timestamp;
				frag_q  <= frag;
				type_q  <= ntype;
			end
			// Advance within the open NAL; a first byte restarts the counters.
			pos_q <= active ? pos_nxt : pos;
			off_q <= (active && frag && pos_ge2) ? off_nxt : off;
			ff_q  <= (active && fu) ? 1'b0 : ff;
			if (head) begin
				seq_q <= seq_q + 16'd1;
			end
		end
	end

endmodule

// File: src/hrfp_emit.sv
// Result run holding register and byte sequencer with output register.
module hrfp_emit import hrfp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  job_t     job,
	output emit_st_t st,
	output logic     out_valid,
	input  logic     out_stall,
	output out_t     out_data
);

	job_t job_s1;
	logic vld_s1;
	idx_t idx_q;
	logic adv;
	logic at_last;

	assign adv      = vld_s1 && (!out_valid || !out_stall);
	assign at_last  = idx_q == job_s1.last_idx;
	assign st.busy  = vld_s1;
	assign st.ready = !vld_s1 || (adv && at_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			vld_s1 <= 1'b1;
			idx_q  <= '0;
		end else if (adv) begin
			idx_q <= at_last ? '0 : idx_q + idx_t'(1);
			if (at_last) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_s1 <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.out_byte  <= job_s1.bytes[idx_q];
			out_data.frame_end <= at_last && job_s1.data_end;
			out_data.run_last  <= at_last;
		end
	end

endmodule
